>>> rtl/dnsd_pkg.sv
// Shared types, codes and constants of the DNS name decompressor.
package dnsd_pkg;

    localparam int PACKET_BYTES_DEF = 512;
    localparam int NAME_BYTES_DEF   = 256;
    localparam int HEADER_BYTES     = 12;

    localparam int START_W    = 9;
    localparam int TARGET_W   = 14;
    localparam int CHUNK_W    = 64;
    localparam int CBYTES_W   = 4;
    localparam int CONSUMED_W = 10;
    localparam int STATUS_W   = 3;
    localparam int LABEL_W    = 9;

    localparam logic [7:0] PTR_MARK  = 8'hC0;
    localparam logic [7:0] DOT_CHAR  = 8'h2E;
    localparam logic [3:0] FULL_CHUNK = 4'd8;

    typedef enum logic {
        OP_LOAD   = 1'b0,
        OP_DECODE = 1'b1
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_JUMP_LOOP  = 3'd1,
        ST_TRUNC_PTR  = 3'd2,
        ST_BEYOND     = 3'd3,
        ST_INTO_HDR   = 3'd4,
        ST_TRUNC_NAME = 3'd5,
        ST_TOO_LONG   = 3'd6
    } t_status;

    typedef struct packed {
        logic                 opcode;
        logic [7:0]           data_byte;
        logic                 final_byte;
        logic [START_W-1:0]   start_offset;
    } t_req;

    typedef struct packed {
        logic [CHUNK_W-1:0]    name_chunk;
        logic [CBYTES_W-1:0]   chunk_bytes;
        logic                  last_chunk;
        logic [CONSUMED_W-1:0] consumed_bytes;
        logic [STATUS_W-1:0]   status;
    } t_result;

    typedef struct packed {
        logic lt;
        logic gt;
    } t_cmp_flags;

endpackage

>>> rtl/dnsd_if.sv
// Request and response channel interfaces of the DNS name decompressor.
interface dnsd_req_if;
    logic                         valid;
    logic                         ready;
    logic                         opcode;
    logic [7:0]                   data_byte;
    logic                         final_byte;
    logic [dnsd_pkg::START_W-1:0] start_offset;

    modport source (output valid, opcode, data_byte, final_byte, start_offset, input ready);
    modport sink   (input valid, opcode, data_byte, final_byte, start_offset, output ready);
endinterface

interface dnsd_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [dnsd_pkg::CHUNK_W-1:0]    name_chunk;
    logic [dnsd_pkg::CBYTES_W-1:0]   chunk_bytes;
    logic                            last_chunk;
    logic [dnsd_pkg::CONSUMED_W-1:0] consumed_bytes;
    logic [dnsd_pkg::STATUS_W-1:0]   status;

    modport source (output valid, name_chunk, chunk_bytes, last_chunk, consumed_bytes, status,
                    input ready);
    modport sink   (input valid, name_chunk, chunk_bytes, last_chunk, consumed_bytes, status,
                    output ready);
endinterface

>>> rtl/dnsd_ram.sv
// Generic simple dual-port RAM with registered read.
module dnsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/dnsd_cmp.sv
// Shared magnitude comparator of the name walk.
module dnsd_cmp #(
    parameter int W = 14
) (
    input  logic [W-1:0]         i_a,
    input  logic                 i_inc,
    input  logic [W-1:0]         i_b,
    output dnsd_pkg::t_cmp_flags o_flags
);
    import dnsd_pkg::*;

    logic [W:0] a_eff;
    logic [W:0] b_ext;

    // optionally compare a+1 so the pointer-tail check needs no extra adder
    assign a_eff = {1'b0, i_a} + (W + 1)'(i_inc);
    assign b_ext = {1'b0, i_b};

    assign o_flags.lt = (a_eff < b_ext);
    assign o_flags.gt = (a_eff > b_ext);
endmodule

>>> rtl/dnsd_walker.sv
// Packet store, name walk sequencer and chunk buffer.
module dnsd_walker #(
    parameter int PACKET_BYTES = dnsd_pkg::PACKET_BYTES_DEF,
    parameter int NAME_BYTES   = dnsd_pkg::NAME_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    input  dnsd_pkg::t_req    i_req,
    output logic              o_res_valid,
    input  logic              i_res_take,
    output dnsd_pkg::t_result o_res
);
    import dnsd_pkg::*;

    localparam int LW  = $clog2(PACKET_BYTES + 1);
    localparam int AW  = $clog2(PACKET_BYTES);
    localparam int PW  = (LW > START_W) ? LW : START_W;
    localparam int CW  = (PW > TARGET_W) ? PW : TARGET_W;
    localparam int RW  = $clog2(NAME_BYTES);
    localparam int TD  = (NAME_BYTES + 7) / 8;
    localparam int TAW = $clog2(TD);

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_CHECK   = 9'b000000010,
        S_EXAM    = 9'b000000100,
        S_PCHK    = 9'b000001000,
        S_PTGT    = 9'b000010000,
        S_FIN     = 9'b000100000,
        S_EMIT_RD = 9'b001000000,
        S_EMIT_LD = 9'b010000000,
        S_DONE1   = 9'b100000000
    } t_state;

    t_state                r_state, n_state;
    logic [LW-1:0]         r_load_idx, n_load_idx;
    logic [LW-1:0]         r_pkt_len, n_pkt_len;
    logic [PW-1:0]         r_pos, n_pos;
    logic [LW-1:0]         r_jumps, n_jumps;
    logic                  r_jumped, n_jumped;
    logic [RW-1:0]         r_rawlen, n_rawlen;
    logic [CONSUMED_W-1:0] r_count, n_count;
    logic [LABEL_W-1:0]    r_label_end, n_label_end;
    logic [CHUNK_W-1:0]    r_chunk, n_chunk;
    logic [5:0]            r_ptr_hi, n_ptr_hi;
    t_status               r_status, n_status;
    logic [TAW-1:0]        r_ridx, n_ridx;

    logic               pkt_we;
    logic [AW-1:0]      pkt_waddr;
    logic [AW-1:0]      pkt_raddr;
    logic [7:0]         pkt_rdata;
    logic               txt_we;
    logic [TAW-1:0]     txt_waddr;
    logic [CHUNK_W-1:0] txt_wdata;
    logic [CHUNK_W-1:0] txt_rdata;

    logic [CW-1:0]      cmp_a;
    t_cmp_flags         cmp_flags;
    logic               req_fire;
    logic [RW-1:0]      k_idx;
    logic [7:0]         txt_char;
    logic [CHUNK_W-1:0] chunk_upd;
    logic [RW-1:0]      olen;
    logic [TAW-1:0]     last_idx;
    logic [TARGET_W-1:0] target;

    dnsd_ram #(.WIDTH(8), .DEPTH(PACKET_BYTES)) u_pkt_ram (
        .i_clk   (i_clk),
        .i_we    (pkt_we),
        .i_waddr (pkt_waddr),
        .i_wdata (i_req.data_byte),
        .i_raddr (pkt_raddr),
        .o_rdata (pkt_rdata)
    );

    dnsd_ram #(.WIDTH(CHUNK_W), .DEPTH(TD)) u_txt_ram (
        .i_clk   (i_clk),
        .i_we    (txt_we),
        .i_waddr (txt_waddr),
        .i_wdata (txt_wdata),
        .i_raddr (r_ridx),
        .o_rdata (txt_rdata)
    );

    dnsd_cmp #(.W(CW)) u_cmp (
        .i_a     (cmp_a),
        .i_inc   (r_state == S_PCHK),
        .i_b     (CW'(r_pkt_len)),
        .o_flags (cmp_flags)
    );

    assign o_req_ready = (r_state == S_IDLE);
    assign req_fire    = i_req_valid && o_req_ready;
    assign target      = {r_ptr_hi, pkt_rdata};
    assign cmp_a       = (r_state == S_PTGT) ? CW'(target) : CW'(r_pos);
    assign pkt_waddr   = r_load_idx[AW-1:0];
    assign pkt_we      = req_fire && (i_req.opcode == OP_LOAD)
                         && (r_load_idx != LW'(PACKET_BYTES));
    assign pkt_raddr   = (r_state == S_PCHK) ? AW'(r_pos + PW'(1)) : r_pos[AW-1:0];

    // text index of the byte just read; a label end becomes a dot
    assign k_idx     = r_rawlen - RW'(1);
    assign txt_char  = (LABEL_W'(k_idx) == r_label_end) ? DOT_CHAR : pkt_rdata;
    assign chunk_upd = r_chunk | (CHUNK_W'(txt_char) << {k_idx[2:0], 3'b000});
    assign olen      = (r_rawlen == '0) ? '0 : r_rawlen - RW'(1);
    assign last_idx  = TAW'((olen - RW'(1)) >> 3);

    always_comb begin
        n_state     = r_state;
        n_load_idx  = r_load_idx;
        n_pkt_len   = r_pkt_len;
        n_pos       = r_pos;
        n_jumps     = r_jumps;
        n_jumped    = r_jumped;
        n_rawlen    = r_rawlen;
        n_count     = r_count;
        n_label_end = r_label_end;
        n_chunk     = r_chunk;
        n_ptr_hi    = r_ptr_hi;
        n_status    = r_status;
        n_ridx      = r_ridx;
        txt_we      = 1'b0;
        txt_waddr   = TAW'(k_idx >> 3);
        txt_wdata   = chunk_upd;
        o_res_valid = 1'b0;
        o_res       = '0;

        case (r_state)
            S_IDLE: begin
                if (req_fire && (i_req.opcode == OP_LOAD)) begin
                    if (r_load_idx != LW'(PACKET_BYTES)) begin
                        n_load_idx = r_load_idx + LW'(1);
                    end
                    if (i_req.final_byte) begin
                        n_pkt_len  = (r_load_idx != LW'(PACKET_BYTES)) ?
                                     r_load_idx + LW'(1) : r_load_idx;
                        n_load_idx = '0;
                    end
                end else if (req_fire) begin
                    n_pos       = PW'(i_req.start_offset);
                    n_jumps     = '0;
                    n_jumped    = 1'b0;
                    n_rawlen    = '0;
                    n_count     = CONSUMED_W'(1);
                    n_label_end = '0;
                    n_chunk     = '0;
                    n_status    = ST_OK;
                    n_state     = S_CHECK;
                end
            end
            S_CHECK: begin
                // read the byte at pos while it lies inside the packet
                if (cmp_flags.lt) begin
                    n_state = S_EXAM;
                end else begin
                    n_status = ST_TRUNC_NAME;
                    n_state  = S_DONE1;
                end
            end
            S_EXAM: begin
                if (pkt_rdata == 8'd0) begin
                    n_state = S_FIN;
                end else if (pkt_rdata >= PTR_MARK) begin
                    if (r_jumps == LW'(PACKET_BYTES)) begin
                        n_status = ST_JUMP_LOOP;
                        n_state  = S_DONE1;
                    end else begin
                        n_jumps  = r_jumps + LW'(1);
                        n_jumped = 1'b1;
                        n_ptr_hi = pkt_rdata[5:0];
                        n_state  = S_PCHK;
                    end
                end else if (r_rawlen == RW'(NAME_BYTES - 1)) begin
                    n_status = ST_TOO_LONG;
                    n_state  = S_DONE1;
                end else begin
                    n_rawlen = r_rawlen + RW'(1);
                    n_pos    = r_pos + PW'(1);
                    if (!r_jumped) begin
                        n_count = r_count + CONSUMED_W'(1);
                    end
                    if (r_rawlen == '0) begin
                        n_label_end = LABEL_W'(pkt_rdata);
                    end else begin
                        if (LABEL_W'(k_idx) == r_label_end) begin
                            n_label_end = LABEL_W'(r_rawlen) + LABEL_W'(pkt_rdata);
                        end
                        if (k_idx[2:0] == 3'd7) begin
                            txt_we  = 1'b1;
                            n_chunk = '0;
                        end else begin
                            n_chunk = chunk_upd;
                        end
                    end
                    n_state = S_CHECK;
                end
            end
            S_PCHK: begin
                // second pointer byte must lie inside the packet
                if (cmp_flags.lt) begin
                    n_state = S_PTGT;
                end else begin
                    n_status = ST_TRUNC_PTR;
                    n_state  = S_DONE1;
                end
            end
            S_PTGT: begin
                if (cmp_flags.gt) begin
                    n_status = ST_BEYOND;
                    n_state  = S_DONE1;
                end else if (target < TARGET_W'(HEADER_BYTES)) begin
                    n_status = ST_INTO_HDR;
                    n_state  = S_DONE1;
                end else begin
                    n_pos   = PW'(target);
                    n_state = S_CHECK;
                end
            end
            S_FIN: begin
                n_count = r_count + CONSUMED_W'(r_jumped);
                n_ridx  = '0;
                if (olen == '0) begin
                    n_state = S_DONE1;
                end else begin
                    // flush the partial last chunk
                    if (olen[2:0] != 3'd0) begin
                        txt_we    = 1'b1;
                        txt_waddr = TAW'(olen >> 3);
                        txt_wdata = r_chunk;
                    end
                    n_state = S_EMIT_RD;
                end
            end
            S_EMIT_RD: begin
                n_state = S_EMIT_LD;
            end
            S_EMIT_LD: begin
                o_res_valid          = 1'b1;
                o_res.name_chunk     = txt_rdata;
                o_res.last_chunk     = (r_ridx == last_idx);
                o_res.consumed_bytes = r_count;
                o_res.status         = ST_OK;
                if ((r_ridx == last_idx) && (olen[2:0] != 3'd0)) begin
                    o_res.chunk_bytes = CBYTES_W'(olen[2:0]);
                end else begin
                    o_res.chunk_bytes = FULL_CHUNK;
                end
                if (i_res_take) begin
                    if (r_ridx == last_idx) begin
                        n_state = S_IDLE;
                    end else begin
                        n_ridx  = r_ridx + TAW'(1);
                        n_state = S_EMIT_RD;
                    end
                end
            end
            S_DONE1: begin
                o_res_valid          = 1'b1;
                o_res.last_chunk     = 1'b1;
                o_res.status         = r_status;
                o_res.consumed_bytes = (r_status == ST_OK) ? r_count : '0;
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_load_idx <= '0;
            r_pkt_len  <= '0;
            r_jumps    <= '0;
            r_rawlen   <= '0;
        end else begin
            r_state    <= n_state;
            r_load_idx <= n_load_idx;
            r_pkt_len  <= n_pkt_len;
            r_jumps    <= n_jumps;
            r_rawlen   <= n_rawlen;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos       <= n_pos;
        r_jumped    <= n_jumped;
        r_count     <= n_count;
        r_label_end <= n_label_end;
        r_chunk     <= n_chunk;
        r_ptr_hi    <= n_ptr_hi;
        r_status    <= n_status;
        r_ridx      <= n_ridx;
    end

    a_decode_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req_fire && (i_req.opcode == OP_DECODE)) |=> (r_state == S_CHECK))
        else $error("decode item did not start the walk");

    a_target_after_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PTGT) |-> ($past(r_state) == S_PCHK))
        else $error("pointer target checked without tail check");

    a_rawlen_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rawlen <= RW'(NAME_BYTES - 1))
        else $error("collected name bytes overran the limit");

    a_jumps_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_jumps <= LW'(PACKET_BYTES))
        else $error("jump counter overran");
endmodule

>>> rtl/dns_name_decompressor_core.sv
// Top level of the DNS name decompressor: walker plus result register.
//
//  channel  dir  handshake      payload
//  i_req    in   valid/ready    opcode, data_byte, final_byte, start_offset
//  o_rsp    out  valid/ready    name_chunk, chunk_bytes, last_chunk,
//                               consumed_bytes, status
//
// A load item leaves the sequencer idle, so the block stays ready for more items.
// A decode item walks the name one label byte or pointer at a time, since
// every step reads the packet store through its single registered read port
// and one shared comparator checks it; then comes a flush step, and each chunk
// is read out of the chunk buffer. Error and empty results skip the buffer.
// Reset (synchronous, active low) clears the sequencer, packet length and load
// index; the packet store needs no clearing pass, it is read only where loaded.
// A stalled result holds in the output register; the walker waits for room.
module dns_name_decompressor_core #(
    parameter int PACKET_BYTES = dnsd_pkg::PACKET_BYTES_DEF,
    parameter int NAME_BYTES   = dnsd_pkg::NAME_BYTES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    dnsd_req_if.sink      i_req,
    dnsd_rsp_if.source    o_rsp
);
    import dnsd_pkg::*;

    t_req    req;
    t_result res;
    t_result r_res;
    logic    res_valid;
    logic    res_take;
    logic    r_valid;

    // gather the request fields into one item
    assign req.opcode       = i_req.opcode;
    assign req.data_byte    = i_req.data_byte;
    assign req.final_byte   = i_req.final_byte;
    assign req.start_offset = i_req.start_offset;

    dnsd_walker #(
        .PACKET_BYTES (PACKET_BYTES),
        .NAME_BYTES   (NAME_BYTES)
    ) u_walker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_req       (req),
        .o_res_valid (res_valid),
        .i_res_take  (res_take),
        .o_res       (res)
    );

    // take a new result when the register is empty or being drained
    assign res_take = res_valid && (!r_valid || o_rsp.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (res_take) begin
            r_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_valid <= 1'b0;
        end
    end

    // payload holds while stalled
    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_res <= res;
        end
    end

    assign o_rsp.valid          = r_valid;
    assign o_rsp.name_chunk     = r_res.name_chunk;
    assign o_rsp.chunk_bytes    = r_res.chunk_bytes;
    assign o_rsp.last_chunk     = r_res.last_chunk;
    assign o_rsp.consumed_bytes = r_res.consumed_bytes;
    assign o_rsp.status         = r_res.status;
endmodule

>>> verif/testbench.sv
// Self-checking testbench of the DNS name decompressor: directed table, random packets, scoreboard.
module testbench;
    import dnsd_pkg::*;

    localparam int unsigned STALL_LIMIT = 20000;  // cycles with no item moved on either side
    localparam int unsigned LONG_HOLD   = 400;    // receiver hold-off that backs the block up
    localparam int unsigned TAIL_CYCLES = 40;

    typedef struct {
        t_req    item;
        bit      typed;
        t_result want;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    dnsd_req_if req_ch ();
    dnsd_rsp_if rsp_ch ();

    dns_name_decompressor_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // Shadow copy of the packet store and its counters
    logic [7:0]  shadow_store [PACKET_BYTES_DEF];
    int unsigned shadow_len;
    int unsigned shadow_fill;

    t_result     awaited_chunks [$];
    int unsigned mismatches;
    bit          quiet;          // no idling on either side while set
    bit          stall_request;  // ask the receiver for one long hold-off

    // Directed packet, 16 bytes:
    //   0: "hi" then a pointer to 12     5: pointer into the header
    //   7: pointer past the packet end   9: root (empty) name
    //  10: second pointer into header   12: "z"
    //  15: pointer cut off by the packet end
    t_row directed_rows [26] = '{
        // nothing loaded yet: the walk runs straight into the packet end
        '{'{OP_DECODE, 8'h00, 1'b0, 9'd0},   1'b1, '{64'd0, 4'd0, 1'b1, 10'd0, ST_TRUNC_NAME}},
        '{'{OP_LOAD,   8'h02, 1'b0, 9'h1FF}, 1'b0, '0},
        '{'{OP_LOAD,   8'h68, 1'b0, 9'd0},   1'b0, '0},
        '{'{OP_LOAD,   8'h69, 1'b0, 9'd0},   1'b0, '0},
        '{'{OP_LOAD,   8'hC0, 1'b0, 9'd0},   1'b0, '0},
        '{'{OP_LOAD,   8'h0C, 1'b0, 9'd0},   1'b0, '0},
        '{'{OP_LOAD,   8'hC0, 1'b0, 9'd0},   1'b0, '0},
        '{'{OP_LOAD,   8'h02, 1'b0, 9'd0},   1'b0, '0},
        '{'{OP_LOAD,   8'hC0, 1'b0, 9'd0},   1'b0, '0},
        '{'{OP_LOAD,   8'h7F, 1'b0, 9'd0},   1'b0, '0},
        '{'{OP_LOAD,   8'h00, 1'b0, 9'd0},   1'b0, '0},
        '{'{OP_LOAD,   8'hC0, 1'b0, 9'd0},   1'b0, '0},
        '{'{OP_LOAD,   8'h0A, 1'b0, 9'd0},   1'b0, '0},
        '{'{OP_LOAD,   8'h01, 1'b0, 9'd0},   1'b0, '0},
        '{'{OP_LOAD,   8'h7A, 1'b0, 9'd0},   1'b0, '0},
        '{'{OP_LOAD,   8'h00, 1'b0, 9'd0},   1'b0, '0},
        '{'{OP_LOAD,   8'hC0, 1'b1, 9'h155}, 1'b0, '0},
        // "hi.z" across a pointer: three label bytes plus the pointer
        '{'{OP_DECODE, 8'h00, 1'b0, 9'd0},   1'b0, '0},
        // length byte claims far more than was collected
        '{'{OP_DECODE, 8'h00, 1'b0, 9'd1},   1'b0, '0},
        '{'{OP_DECODE, 8'h00, 1'b0, 9'd5},   1'b1, '{64'd0, 4'd0, 1'b1, 10'd0, ST_INTO_HDR}},
        '{'{OP_DECODE, 8'h00, 1'b0, 9'd7},   1'b1, '{64'd0, 4'd0, 1'b1, 10'd0, ST_BEYOND}},
        '{'{OP_DECODE, 8'h00, 1'b0, 9'd9},   1'b1, '{64'd0, 4'd0, 1'b1, 10'd1, ST_OK}},
        '{'{OP_DECODE, 8'h00, 1'b0, 9'd10},  1'b1, '{64'd0, 4'd0, 1'b1, 10'd0, ST_INTO_HDR}},
        '{'{OP_DECODE, 8'h00, 1'b0, 9'd15},  1'b1, '{64'd0, 4'd0, 1'b1, 10'd0, ST_TRUNC_PTR}},
        '{'{OP_DECODE, 8'h00, 1'b0, 9'd12},  1'b0, '0},
        // data and final are don't-care on a decode
        '{'{OP_DECODE, 8'hFF, 1'b1, 9'h1FF}, 1'b1, '{64'd0, 4'd0, 1'b1, 10'd0, ST_TRUNC_NAME}}
    };

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Walk the shadow store from one offset and cut the dotted name into chunks.
    function automatic void walk_name(input logic [START_W-1:0] start, output t_result outs [$]);
        logic [7:0]  raw  [NAME_BYTES_DEF];
        logic [7:0]  text [NAME_BYTES_DEF];
        logic [7:0]  b;
        int unsigned pos, count, jumps, rawlen, olen, label_end, aim, base, n;
        bit          jumped;
        t_status     st;
        t_result     one;
        outs.delete();
        pos    = start;
        count  = 1;
        jumps  = 0;
        rawlen = 0;
        jumped = 1'b0;
        st     = ST_OK;
        while (st == ST_OK && pos < shadow_len && shadow_store[pos] != 8'h00) begin
            b = shadow_store[pos];
            if (b >= PTR_MARK) begin
                jumps++;
                if (jumps > PACKET_BYTES_DEF) begin
                    st = ST_JUMP_LOOP;
                end else if (pos + 1 >= shadow_len) begin
                    st = ST_TRUNC_PTR;
                end else begin
                    jumped = 1'b1;
                    aim = {b[5:0], shadow_store[pos + 1]};
                    if (aim > shadow_len) st = ST_BEYOND;
                    else if (aim < HEADER_BYTES) st = ST_INTO_HDR;
                    else pos = aim;
                end
            end else if (rawlen >= NAME_BYTES_DEF - 1) begin
                st = ST_TOO_LONG;
            end else begin
                raw[rawlen] = b;
                rawlen++;
                pos++;
                if (!jumped) count++;
            end
        end
        if (st == ST_OK && pos >= shadow_len) st = ST_TRUNC_NAME;
        if (st != ST_OK) begin
            one = '{64'd0, 4'd0, 1'b1, 10'd0, st};
            outs = {outs, one};
            return;
        end
        if (jumped) count++;

        // Replace every label length byte but the first with a dot
        olen      = (rawlen != 0) ? rawlen - 1 : 0;
        label_end = (rawlen != 0) ? raw[0] : 0;
        for (int unsigned k = 0; k < olen; k++) begin
            if (k == label_end) begin
                text[k]   = DOT_CHAR;
                label_end = k + 1 + raw[k + 1];
            end else begin
                text[k] = raw[k + 1];
            end
        end

        if (olen == 0) begin
            one = '{64'd0, 4'd0, 1'b1, count[CONSUMED_W-1:0], ST_OK};
            outs = {outs, one};
            return;
        end
        for (base = 0; base < olen; base += 8) begin
            n = (olen - base > 8) ? 8 : olen - base;
            one = '0;
            for (int unsigned i = 0; i < n; i++) one.name_chunk[8*i +: 8] = text[base + i];
            one.chunk_bytes    = n[CBYTES_W-1:0];
            one.last_chunk     = (base + 8 >= olen);
            one.consumed_bytes = count[CONSUMED_W-1:0];
            one.status         = ST_OK;
            outs = {outs, one};
        end
    endfunction

    // Apply one accepted item to the shadow state; decodes yield their chunks.
    function automatic void track_item(input t_req item, output t_result outs [$]);
        outs.delete();
        if (item.opcode == OP_DECODE) begin
            walk_name(item.start_offset, outs);
            return;
        end
        // drop bytes past the end of the store
        if (shadow_fill < PACKET_BYTES_DEF) begin
            shadow_store[shadow_fill] = item.data_byte;
            shadow_fill++;
        end
        if (item.final_byte) begin
            shadow_len  = shadow_fill;
            shadow_fill = 0;
        end
    endfunction

    // Offer one item, wait for the handshake, then record what it should produce.
    task automatic offer_item(input t_req item, input bit typed = 1'b0,
                              input t_result want = '0);
        t_result fresh [$];
        while (!quiet && $urandom_range(99) < 16) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.opcode       <= item.opcode;
        req_ch.data_byte    <= item.data_byte;
        req_ch.final_byte   <= item.final_byte;
        req_ch.start_offset <= item.start_offset;
        do @(posedge i_clk); while (!req_ch.ready);
        track_item(item, fresh);
        if (typed) awaited_chunks = {awaited_chunks, want};
        else foreach (fresh[i]) awaited_chunks = {awaited_chunks, fresh[i]};
    endtask

    // Drop valid and hold until every awaited chunk has come back.
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (awaited_chunks.size() != 0) @(posedge i_clk);
    endtask

    // Most decodes hit a real name start; the rest land anywhere.
    function automatic logic [START_W-1:0] pick_start(input int unsigned heads [$],
                                                      input int unsigned span);
        int unsigned roll, spot;
        roll = $urandom_range(99);
        if (roll < 70 && heads.size() != 0) spot = heads[$urandom_range(heads.size() - 1)];
        else if (roll < 85) spot = $urandom_range(span - 1);
        else spot = $urandom_range(511);
        if (spot > 511) spot = HEADER_BYTES;
        return spot[START_W-1:0];
    endfunction

    // Build a packet: random header, then names of up to three labels, each
    // closed by a root byte, a pointer to an earlier name, or now and then a
    // broken pointer or a pointer back to its own start.
    task automatic build_packet(input int unsigned want_len, input bit with_spin,
                                output logic [7:0] img [$], output int unsigned heads [$]);
        int unsigned here, labels, ln, roll, aim;
        img.delete();
        heads.delete();
        repeat (HEADER_BYTES) img = {img, 8'($urandom_range(255))};
        do begin
            here = img.size();
            heads = {heads, here};
            labels = $urandom_range(3);
            repeat (labels) begin
                ln = $urandom_range(1, 12);
                if ($urandom_range(99) < 5) img = {img, 8'(ln + $urandom_range(1, 4))};
                else img = {img, 8'(ln)};
                repeat (ln) begin
                    if ($urandom_range(99) < 3) img = {img, 8'($urandom_range(255))};
                    else img = {img, 8'($urandom_range(1, 8'hBF))};
                end
            end
            roll = $urandom_range(99);
            aim  = 0;
            if (with_spin && roll < 6) aim = here;
            else if (roll < 40 && heads.size() > 1) aim = heads[$urandom_range(heads.size() - 2)];
            else if (roll < 45) aim = $urandom_range(16'h3FFF);
            if (roll < 45 && (aim != 0 || roll < 6)) begin
                img = {img, PTR_MARK | 8'(aim >> 8)};
                img = {img, 8'(aim)};
            end else begin
                img = {img, 8'h00};
            end
        end while (img.size() < want_len);
    endtask

    // Result side: check each chunk against the oldest one awaited, stall at
    // random, and honor one long hold-off when asked.
    function automatic void compare_field(input string fname, input logic [63:0] want,
                                          input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", fname, want, got);
            mismatches++;
        end
    endfunction

    initial begin : result_sink
        int unsigned hold_left;
        t_result     want;
        hold_left = 0;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
                if (awaited_chunks.size() == 0) begin
                    $error("chunk %0h arrived with nothing awaited", rsp_ch.name_chunk);
                    mismatches++;
                end else begin
                    want = awaited_chunks.pop_front();
                    compare_field("name_chunk",     want.name_chunk,     rsp_ch.name_chunk);
                    compare_field("chunk_bytes",    want.chunk_bytes,    rsp_ch.chunk_bytes);
                    compare_field("last_chunk",     want.last_chunk,     rsp_ch.last_chunk);
                    compare_field("consumed_bytes", want.consumed_bytes, rsp_ch.consumed_bytes);
                    compare_field("status",         want.status,         rsp_ch.status);
                end
            end
            if (stall_request) begin
                stall_request = 1'b0;
                hold_left     = LONG_HOLD;
            end
            if (hold_left != 0) begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= quiet || ($urandom_range(99) >= 16);
            end
        end
    end

    // End the run if nothing moves on either side for too long.
    initial begin : watchdog
        int unsigned still;
        still = 0;
        while (still < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) still = 0;
            else still++;
        end
        $display("dns_name_decompressor_core test failed");
        $finish;
    end

    initial begin : stimulus
        t_req        it;
        logic [7:0]  image [$];
        int unsigned heads [$];
        int unsigned prev_heads [$];
        int unsigned prev_span;
        mismatches    = 0;
        quiet         = 1'b0;
        stall_request = 1'b0;
        shadow_len    = 0;
        shadow_fill   = 0;
        req_ch.valid        <= 1'b0;
        req_ch.opcode       <= OP_LOAD;
        req_ch.data_byte    <= 8'h00;
        req_ch.final_byte   <= 1'b0;
        req_ch.start_offset <= '0;
        i_rst_n             <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i])
            offer_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
        wait_drained();

        prev_heads = '{0, 1, 9, 12};
        prev_span  = 16;
        // Round 1 runs without idling, round 2 backs the block up behind a
        // long receiver hold-off.
        for (int unsigned round = 0; round < 3; round++) begin
            quiet = (round == 1);
            build_packet($urandom_range(16, 28), round != 0, image, heads);
            foreach (image[i]) begin
                // now and then decode the old packet while the new one is partly loaded
                if (round != 0 && $urandom_range(99) < 6) begin
                    it = '{OP_DECODE, 8'($urandom), 1'($urandom), pick_start(prev_heads, prev_span)};
                    offer_item(it);
                end
                it = '{OP_LOAD, image[i], i == image.size() - 1, 9'($urandom)};
                offer_item(it);
            end
            if (round == 2) stall_request = 1'b1;
            prev_span  = (image.size() > PACKET_BYTES_DEF) ? PACKET_BYTES_DEF : image.size();
            prev_heads = heads;
            repeat (10) begin
                it = '{OP_DECODE, 8'($urandom), 1'($urandom), pick_start(heads, prev_span)};
                offer_item(it);
            end
            wait_drained();
        end
        quiet = 1'b0;

        // Leave room for any stray chunk to show up
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("dns_name_decompressor_core test passed");
        end else begin
            $display("dns_name_decompressor_core test failed");
        end
        $finish;
    end

endmodule

>>> dns_name_decompressor_core.f
rtl/dnsd_pkg.sv
rtl/dnsd_if.sv
rtl/dnsd_ram.sv
rtl/dnsd_cmp.sv
rtl/dnsd_walker.sv
rtl/dns_name_decompressor_core.sv
verif/testbench.sv
